// ===== rtl/gbn_pkg.sv =====
// Shared constants for the go-back-n sender window.
`default_nettype none
package gbn_pkg;
	localparam int SEQ_SPACE = 16;
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int REF_W     = 32;
	localparam int LEN_W     = 7;
	localparam int MAX_LEN   = 127;
	localparam int WIN_W     = 4;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

	localparam logic [1:0] ACT_NEW     = 2'd0;
	localparam logic [1:0] ACT_ACK     = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/gbn_in_if.sv =====
// Input channel: one event transaction per handshake.
`default_nettype none
interface gbn_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [gbn_pkg::REF_W-1:0]  payload_ref;
	logic [gbn_pkg::LEN_W-1:0]  payload_len;
	logic [gbn_pkg::SEQ_W-1:0]  ack_seq;
	logic                       ack_ok;

	modport source (output valid, action, payload_ref, payload_len, ack_seq, ack_ok,
		input ready);
	modport sink (input valid, action, payload_ref, payload_len, ack_seq, ack_ok,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/gbn_out_if.sv =====
// Output channel: one send or status transaction per handshake.
`default_nettype none
interface gbn_out_if;
	logic                       valid;
	logic                       ready;
	logic                       is_send;
	logic [gbn_pkg::SEQ_W-1:0]  send_seq;
	logic [gbn_pkg::REF_W-1:0]  send_ref;
	logic [gbn_pkg::LEN_W-1:0]  send_len;
	logic                       timer_start;
	logic                       timer_stop;
	logic                       accepted;
	logic                       last;

	modport source (output valid, is_send, send_seq, send_ref, send_len, timer_start,
		timer_stop, accepted, last, input ready);
	modport sink (input valid, is_send, send_seq, send_ref, send_len, timer_start,
		timer_stop, accepted, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/go_back_n_sender_window.sv =====
// Go-back-n sender window: sequencer, packet store and output register.
// New message / ack: the execute state loads the result into the output register once it is free.
// Timeout with N outstanding: the execute state issues the first packet store read, then the
// resend state sends one per cycle from the read port while the output register is free.
// Input is taken only in the idle state; the output register lets the next event
// enter while the previous result waits. Async reset clears window state and sets
// window_size to 4; the packet store is not cleared.
`default_nettype none
module go_back_n_sender_window (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [gbn_pkg::WIN_W-1:0]   cfg_wdata,
	gbn_in_if.sink                           in_ch,
	gbn_out_if.source                        out_ch
);
	localparam int SW = gbn_pkg::SEQ_W;
	localparam int RW = gbn_pkg::REF_W;
	localparam int LW = gbn_pkg::LEN_W;
	localparam logic [SW-1:0] WIN_MAX = SW'(gbn_pkg::SEQ_SPACE - 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(gbn_pkg::MAX_LEN);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RPLY} state_t;

	state_t                 state_q;
	logic [gbn_pkg::WIN_W-1:0] win_q;
	logic [SW-1:0]          base_q;
	logic [SW-1:0]          next_q;
	logic [1:0]             act_q;
	logic [RW-1:0]          ref_q;
	logic [LW-1:0]          len_q;
	logic [SW-1:0]          ack_q;
	logic                   ok_q;
	logic [SW-1:0]          rd_seq_q;
	logic [RW+LW-1:0]       rd_data_q;
	logic [RW+LW-1:0]       mem [gbn_pkg::SEQ_SPACE];

	logic                   out_valid_q;
	logic                   o_send_q;
	logic [SW-1:0]          o_seq_q;
	logic [RW-1:0]          o_ref_q;
	logic [LW-1:0]          o_len_q;
	logic                   o_tstart_q;
	logic                   o_tstop_q;
	logic                   o_acc_q;
	logic                   o_last_q;

	logic                   in_fire;
	logic                   out_free;
	logic                   out_load;
	logic [SW-1:0]          win_eff;
	logic [SW-1:0]          outst;
	logic [SW-1:0]          ack_dist;
	logic [SW-1:0]          inc_a;
	logic [SW-1:0]          inc;
	logic                   mem_we;
	logic                   rd_en;
	logic [SW-1:0]          rd_addr;
	logic                   ack_good;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign win_eff  = (SW'(win_q) > WIN_MAX) ? WIN_MAX : SW'(win_q);
	assign outst    = next_q - base_q;
	assign ack_dist = ack_q - base_q;
	assign ack_good = ok_q && (ack_dist < outst);

	// shared sequence incrementer
	always_comb begin
		unique case (state_q)
			S_RPLY:  inc_a = rd_seq_q;
			default: inc_a = (act_q == gbn_pkg::ACT_ACK) ? ack_q : next_q;
		endcase
	end
	assign inc = inc_a + SW'(1);

	always_comb begin
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = base_q;
		out_load = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				if (act_q == gbn_pkg::ACT_NEW && out_free && outst < win_eff)
					mem_we = 1'b1;
				if (act_q == gbn_pkg::ACT_TIMEOUT && outst != '0)
					rd_en = 1'b1;
				if (out_free && (act_q == gbn_pkg::ACT_NEW || act_q == gbn_pkg::ACT_ACK
					|| (act_q == gbn_pkg::ACT_TIMEOUT && outst == '0)))
					out_load = 1'b1;
			end
			S_RPLY: begin
				rd_addr  = inc;
				out_load = out_free;
				if (out_free && inc != next_q)
					rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[next_q] <= {ref_q, len_q};
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= gbn_pkg::WIN_RESET;
			base_q      <= '0;
			next_q      <= '0;
			act_q       <= gbn_pkg::ACT_NEW;
			ref_q       <= '0;
			len_q       <= '0;
			ack_q       <= '0;
			ok_q        <= 1'b0;
			rd_seq_q    <= '0;
			out_valid_q <= 1'b0;
			o_send_q    <= 1'b0;
			o_seq_q     <= '0;
			o_ref_q     <= '0;
			o_len_q     <= '0;
			o_tstart_q  <= 1'b0;
			o_tstop_q   <= 1'b0;
			o_acc_q     <= 1'b0;
			o_last_q    <= 1'b0;
		end else begin
			if (cfg_we)
				win_q <= cfg_wdata;
			if (out_valid_q && out_ch.ready && !out_load)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						act_q <= in_ch.action;
						ref_q <= in_ch.payload_ref;
						len_q <= (in_ch.payload_len > LEN_MAX) ? LEN_MAX : in_ch.payload_len;
						ack_q <= in_ch.ack_seq;
						ok_q  <= in_ch.ack_ok;
						if (in_ch.action == gbn_pkg::ACT_NEW || in_ch.action == gbn_pkg::ACT_ACK
							|| in_ch.action == gbn_pkg::ACT_TIMEOUT)
							state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						gbn_pkg::ACT_NEW: begin
							if (out_free) begin
								out_valid_q <= 1'b1;
								o_tstop_q   <= 1'b0;
								o_last_q    <= 1'b1;
								if (outst < win_eff) begin
									o_send_q   <= 1'b1;
									o_seq_q    <= next_q;
									o_ref_q    <= ref_q;
									o_len_q    <= len_q;
									o_tstart_q <= (outst == '0);
									o_acc_q    <= 1'b1;
									next_q     <= inc;
								end else begin
									o_send_q   <= 1'b0;
									o_seq_q    <= '0;
									o_ref_q    <= '0;
									o_len_q    <= '0;
									o_tstart_q <= 1'b0;
									o_acc_q    <= 1'b0;
								end
								state_q <= S_IDLE;
							end
						end
						gbn_pkg::ACT_ACK: begin
							if (out_free) begin
								out_valid_q <= 1'b1;
								o_send_q    <= 1'b0;
								o_seq_q     <= '0;
								o_ref_q     <= '0;
								o_len_q     <= '0;
								o_tstart_q  <= 1'b0;
								o_last_q    <= 1'b1;
								o_acc_q     <= ack_good;
								o_tstop_q   <= ack_good && (inc == next_q);
								if (ack_good)
									base_q <= inc;
								state_q <= S_IDLE;
							end
						end
						gbn_pkg::ACT_TIMEOUT: begin
							if (outst != '0) begin
								rd_seq_q <= base_q;
								state_q  <= S_RPLY;
							end else if (out_free) begin
								out_valid_q <= 1'b1;
								o_send_q    <= 1'b0;
								o_seq_q     <= '0;
								o_ref_q     <= '0;
								o_len_q     <= '0;
								o_tstart_q  <= 1'b1;
								o_tstop_q   <= 1'b0;
								o_acc_q     <= 1'b0;
								o_last_q    <= 1'b1;
								state_q     <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RPLY: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						o_send_q    <= 1'b1;
						o_seq_q     <= rd_seq_q;
						o_ref_q     <= rd_data_q[RW+LW-1:LW];
						o_len_q     <= rd_data_q[LW-1:0];
						o_tstart_q  <= (rd_seq_q == base_q);
						o_tstop_q   <= 1'b0;
						o_acc_q     <= 1'b0;
						o_last_q    <= (inc == next_q);
						rd_seq_q    <= inc;
						if (inc == next_q)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.is_send     = o_send_q;
	assign out_ch.send_seq    = o_seq_q;
	assign out_ch.send_ref    = o_ref_q;
	assign out_ch.send_len    = o_len_q;
	assign out_ch.timer_start = o_tstart_q;
	assign out_ch.timer_stop  = o_tstop_q;
	assign out_ch.accepted    = o_acc_q;
	assign out_ch.last        = o_last_q;
endmodule
`default_nettype wire

// ===== tb/gbn_window_tracker.sv =====
// Scoreboard for the go-back-n sender window: window state model and result checker.
`timescale 1ns / 1ps
package gbn_tb_pkg;
	import gbn_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [REF_W-1:0] payload_ref;
		logic [LEN_W-1:0] payload_len;
		logic [SEQ_W-1:0] ack_seq;
		logic             ack_ok;
	} gbn_event_t;

	typedef struct packed {
		logic             is_send;
		logic [SEQ_W-1:0] send_seq;
		logic [REF_W-1:0] send_ref;
		logic [LEN_W-1:0] send_len;
		logic             timer_start;
		logic             timer_stop;
		logic             accepted;
		logic             last;
	} gbn_result_t;

	class gbn_window_tracker;
		logic [WIN_W-1:0] window_size;
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] next_seq;
		logic [REF_W-1:0] kept_ref [SEQ_SPACE];
		logic [LEN_W-1:0] kept_len [SEQ_SPACE];
		gbn_result_t      due[$];
		int               errors;

		function new();
			window_size = WIN_RESET;
			base        = '0;
			next_seq    = '0;
			errors      = 0;
		endfunction

		function int seq_gap(int from, int to);
			return (to - from + SEQ_SPACE) % SEQ_SPACE;
		endfunction

		function int in_flight();
			return seq_gap(base, next_seq);
		endfunction

		function int window_limit();
			return (window_size > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : int'(window_size);
		endfunction

		// Accepted input transaction: work out the results it must produce.
		function void note_event(gbn_event_t ev);
			gbn_result_t r;
			int          busy;
			int          len;
			busy   = in_flight();
			r      = '0;
			r.last = 1'b1;
			case (ev.action)
				ACT_NEW: begin
					len = ev.payload_len;
					if (len > MAX_LEN)
						len = MAX_LEN;
					if (busy < window_limit()) begin
						kept_ref[next_seq] = ev.payload_ref;
						kept_len[next_seq] = LEN_W'(len);
						r.is_send     = 1'b1;
						r.send_seq    = next_seq;
						r.send_ref    = ev.payload_ref;
						r.send_len    = LEN_W'(len);
						r.timer_start = (busy == 0);
						r.accepted    = 1'b1;
						next_seq      = SEQ_W'((next_seq + 1) % SEQ_SPACE);
					end
					due.push_back(r);
				end
				ACT_ACK: begin
					if (ev.ack_ok && seq_gap(base, ev.ack_seq) < busy) begin
						base         = SEQ_W'((ev.ack_seq + 1) % SEQ_SPACE);
						r.accepted   = 1'b1;
						r.timer_stop = (base == next_seq);
					end
					due.push_back(r);
				end
				ACT_TIMEOUT: begin
					if (busy == 0) begin
						r.timer_start = 1'b1;
						due.push_back(r);
					end else begin
						for (int i = 0; i < busy; i++) begin
							r             = '0;
							r.is_send     = 1'b1;
							r.send_seq    = SEQ_W'((base + i) % SEQ_SPACE);
							r.send_ref    = kept_ref[r.send_seq];
							r.send_len    = kept_len[r.send_seq];
							r.timer_start = (i == 0);
							r.last        = (i + 1 == busy);
							due.push_back(r);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void match_field(string name, longint unsigned want, longint unsigned seen);
			if (want != seen) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, seen);
				errors++;
			end
		endfunction

		// Accepted output transaction: compare with the oldest pending result.
		function void check_output(gbn_result_t got);
			gbn_result_t want;
			if (due.size() == 0) begin
				$display("%0t: result with none pending, expected nothing got %h", $time, got);
				errors++;
				return;
			end
			want = due.pop_front();
			match_field("is_send", want.is_send, got.is_send);
			match_field("send_seq", want.send_seq, got.send_seq);
			match_field("send_ref", want.send_ref, got.send_ref);
			match_field("send_len", want.send_len, got.send_len);
			match_field("timer_start", want.timer_start, got.timer_start);
			match_field("timer_stop", want.timer_stop, got.timer_stop);
			match_field("accepted", want.accepted, got.accepted);
			match_field("last", want.last, got.last);
		endfunction
	endclass
endpackage

// ===== tb/tb_go_back_n_sender_window.sv =====
// Testbench top for go_back_n_sender_window: stimulus, handshake driving and checking.
`timescale 1ns / 1ps
module tb_go_back_n_sender_window;
	import gbn_pkg::*;
	import gbn_tb_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int PHASE_ITEMS   = 50;
	localparam int NUM_PHASES    = 8;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [WIN_W-1:0] cfg_wdata;
	bit               steady    = 1'b0;
	bit               hold_long = 1'b0;
	logic [WIN_W-1:0] phase_win [NUM_PHASES] = '{4'd15, 4'd1, 4'd8, 4'd3, 4'd12, 4'd2, 4'd6,
		4'd15};

	gbn_in_if  in_ch();
	gbn_out_if out_ch();

	go_back_n_sender_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	gbn_window_tracker book = new();

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic gbn_event_t make_event(logic [1:0] act, logic [REF_W-1:0] pref,
		logic [LEN_W-1:0] plen, logic [SEQ_W-1:0] aseq, logic ok);
		return gbn_event_t'({act, pref, plen, aseq, ok});
	endfunction

	// Mix of new, ack, timeout and unused events; acks are mostly in-range good acks, the rest is noise.
	function automatic gbn_event_t random_event();
		gbn_event_t ev;
		int         pick;
		int         busy;
		busy = book.in_flight();
		ev   = make_event(ACT_NEW, $urandom, LEN_W'($urandom), SEQ_W'($urandom), 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			ev.action = ACT_NEW;
		end else if (pick < 80) begin
			ev.action = ACT_ACK;
			if (busy > 0 && $urandom_range(0, 9) < 8) begin
				ev.ack_ok  = 1'b1;
				ev.ack_seq = SEQ_W'((book.base + $urandom_range(0, busy - 1)) % SEQ_SPACE);
			end
		end else if (pick < 97) begin
			ev.action = ACT_TIMEOUT;
		end else begin
			ev.action = ACT_UNUSED;
		end
		return ev;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic push_event(input gbn_event_t ev);
		int gap;
		if (!steady && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.action      <= ev.action;
		in_ch.payload_ref <= ev.payload_ref;
		in_ch.payload_len <= ev.payload_len;
		in_ch.ack_seq     <= ev.ack_seq;
		in_ch.ack_ok      <= ev.ack_ok;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (book.due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we           <= 1'b0;
		book.window_size = val;
	endtask

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			book.note_event(gbn_event_t'({in_ch.action, in_ch.payload_ref, in_ch.payload_len,
				in_ch.ack_seq, in_ch.ack_ok}));
		if (arst_n && out_ch.valid && out_ch.ready)
			book.check_output(gbn_result_t'({out_ch.is_send, out_ch.send_seq, out_ch.send_ref,
				out_ch.send_len, out_ch.timer_start, out_ch.timer_stop, out_ch.accepted,
				out_ch.last}));
	end

	// Result receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_long) begin
					stall_left = HOLD_CYCLES;
					hold_long  = 1'b0;
				end else if (!steady && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 10);
				end
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** go_back_n_sender_window: FAILED **");
		$finish;
	end

	initial begin
		in_ch.valid       <= 1'b0;
		in_ch.action      <= ACT_NEW;
		in_ch.payload_ref <= '0;
		in_ch.payload_len <= '0;
		in_ch.ack_seq     <= '0;
		in_ch.ack_ok      <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		arst_n            <= 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window 4 after reset
		push_event(make_event(ACT_TIMEOUT, '0, '0, '0, 1'b0));
		push_event(make_event(ACT_ACK, '0, '0, 4'd0, 1'b1));
		push_event(make_event(ACT_NEW, 32'h0000_0000, 7'd0, '0, 1'b0));
		push_event(make_event(ACT_NEW, 32'hFFFF_FFFF, 7'd127, 4'hF, 1'b1));
		push_event(make_event(ACT_NEW, 32'hA5A5_A5A5, 7'd85, '0, 1'b0));
		push_event(make_event(ACT_NEW, 32'h5A5A_5A5A, 7'd42, '0, 1'b0));
		push_event(make_event(ACT_NEW, 32'h1234_5678, 7'd1, '0, 1'b0));
		push_event(make_event(ACT_ACK, '0, '0, 4'd1, 1'b0));
		push_event(make_event(ACT_ACK, '0, '0, 4'd4, 1'b1));
		push_event(make_event(ACT_TIMEOUT, '0, '0, '0, 1'b0));
		push_event(make_event(ACT_ACK, '0, '0, 4'd1, 1'b1));
		push_event(make_event(ACT_UNUSED, 32'hDEAD_BEEF, 7'd5, 4'd2, 1'b1));
		push_event(make_event(ACT_ACK, '0, '0, 4'd3, 1'b1));

		// zero window refuses every new message
		settle();
		write_window(4'd0);
		push_event(make_event(ACT_NEW, 32'h0BAD_F00D, 7'd9, '0, 1'b0));

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_window(phase_win[p]);
			if (p == 0)
				hold_long = 1'b1;
			if (p == NUM_PHASES - 1)
				steady = 1'b1;
			while (book.in_flight() < book.window_limit())
				push_event(make_event(ACT_NEW, $urandom, LEN_W'($urandom), SEQ_W'($urandom),
					1'($urandom)));
			push_event(make_event(ACT_TIMEOUT, $urandom, LEN_W'($urandom), SEQ_W'($urandom),
				1'($urandom)));
			repeat (PHASE_ITEMS) push_event(random_event());
		end

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (book.errors == 0 && book.due.size() == 0)
			$display("** go_back_n_sender_window: PASSED **");
		else
			$display("** go_back_n_sender_window: FAILED **");
		$finish;
	end
endmodule
